// ----- rtl/core/stft_pkg.sv -----
// ============================================================================
// STFT spectrogram package
// Shared sizes, word types, elaboration-time window and twiddle tables, and
// the small helper functions of the datapath.
// ============================================================================
package stft_pkg;

    typedef longint unsigned t_u64;

    localparam int FFT_SIZE = 256;
    localparam int LOG2_N   = $clog2(FFT_SIZE);
    localparam int ADDR_W   = LOG2_N;
    localparam int HALF_N   = FFT_SIZE / 2;
    localparam int QUARTER_N = FFT_SIZE / 4;
    localparam int EIGHTH_N = FFT_SIZE / 8;
    localparam int STG_W    = $clog2(LOG2_N);
    localparam int FILL_W   = ADDR_W + 1;

    localparam int SMP_W    = 16;
    localparam int DATA_W   = 28;
    localparam int MUL_W    = 2 * DATA_W;
    localparam int ACC_W    = MUL_W + 2;
    localparam int TW_W     = 18;
    localparam int HANN_W   = 17;
    localparam int MAG_W    = 24;
    localparam int PAIR_W   = 6;
    localparam int FRAME_W  = 10;
    localparam int HOP_W    = 9;
    localparam int CFG_W    = 10;

    localparam logic [MAG_W-1:0] MAG_MAX = '1;

    // Configuration register indexes.
    localparam logic CFG_HOP_LENGTH        = 1'b0;
    localparam logic CFG_FRAMES_PER_SIGNAL = 1'b1;

    localparam longint ONE_Q30    = 64'sd1073741824;
    localparam t_u64   TWO_PI_Q32 = 64'd26986075409;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic                    first;
    } t_in_word;

    typedef struct packed {
        logic [PAIR_W-1:0]  pair_index;
        logic [MAG_W-1:0]   magnitude_even;
        logic [MAG_W-1:0]   magnitude_odd;
        logic [FRAME_W-1:0] frame_number;
        logic               last;
    } t_out_word;

    typedef struct packed {
        logic                    en;
        logic [ADDR_W-1:0]       addr;
        logic signed [SMP_W-1:0] data;
    } t_smp_wr;

    typedef struct packed {
        logic [ADDR_W-1:0]  offset;
        logic [FRAME_W-1:0] frame;
    } t_frame_cmd;

    typedef logic signed [TW_W-1:0] t_tw_tab [HALF_N];
    typedef logic [HANN_W-1:0]      t_hann_tab [FFT_SIZE];

    // Taylor term divisors: cosine terms first, then sine terms.
    function automatic t_u64 f_taylor_div(input t_u64 v, input int sel);
        t_u64 r;
        r = v;
        case (sel)
            0:  r = v / 2;
            1:  r = v / 12;
            2:  r = v / 30;
            3:  r = v / 56;
            4:  r = v / 90;
            5:  r = v / 132;
            6:  r = v / 6;
            7:  r = v / 20;
            8:  r = v / 42;
            9:  r = v / 72;
            10: r = v / 110;
            default: r = v / 156;
        endcase
        return r;
    endfunction

    function automatic longint f_rnd_c(input longint v, input int sh);
        longint half;
        half = longint'(1) <<< (sh - 1);
        if (v >= 0) begin
            return (v + half) >>> sh;
        end
        return -(((-v) + half) >>> sh);
    endfunction

    // Cosine or sine of 2*pi*k/FFT_SIZE in Q30, evaluated over one octant.
    function automatic longint f_trig30(input int k, input bit want_sin);
        t_u64   x;
        t_u64   x2;
        t_u64   tc;
        t_u64   ts;
        longint cs;
        longint sn;
        longint t;
        longint c;
        longint s;
        int     r;
        int     q;
        int     m;
        bit     swap;
        r = k & (FFT_SIZE - 1);
        q = r / QUARTER_N;
        m = r % QUARTER_N;
        swap = (m > EIGHTH_N);
        if (swap) begin
            m = QUARTER_N - m;
        end
        x  = (t_u64'(m) * TWO_PI_Q32 + t_u64'(2 * FFT_SIZE)) >> (LOG2_N + 2);
        x2 = (x * x) >> 30;
        tc = t_u64'(ONE_Q30);
        ts = x;
        cs = ONE_Q30;
        sn = longint'(x);
        for (int n = 1; n <= 6; n++) begin
            tc = f_taylor_div((tc * x2) >> 30, n - 1);
            ts = f_taylor_div((ts * x2) >> 30, n + 5);
            if ((n & 1) != 0) begin
                cs = cs - longint'(tc);
                sn = sn - longint'(ts);
            end else begin
                cs = cs + longint'(tc);
                sn = sn + longint'(ts);
            end
        end
        if (swap) begin
            t  = cs;
            cs = sn;
            sn = t;
        end
        case (q & 3)
            0: begin c = cs;  s = sn;  end
            1: begin c = -sn; s = cs;  end
            2: begin c = -cs; s = -sn; end
            default: begin c = sn; s = -cs; end
        endcase
        return want_sin ? s : c;
    endfunction

    function automatic t_tw_tab f_tw_tab(input bit want_sin);
        t_tw_tab tab;
        for (int k = 0; k < HALF_N; k++) begin
            tab[k] = TW_W'(f_rnd_c(f_trig30(k, want_sin), 14));
        end
        return tab;
    endfunction

    function automatic t_hann_tab f_hann_tab();
        t_hann_tab tab;
        longint    d;
        for (int k = 0; k < FFT_SIZE; k++) begin
            d = ONE_Q30 - f_trig30(k, 1'b0);
            if (d < 0) begin
                d = 0;
            end
            tab[k] = HANN_W'(f_rnd_c(d, 15));
        end
        return tab;
    endfunction

    localparam t_tw_tab   COS_TAB  = f_tw_tab(1'b0);
    localparam t_tw_tab   SIN_TAB  = f_tw_tab(1'b1);
    localparam t_hann_tab HANN_TAB = f_hann_tab();

    function automatic logic [ADDR_W-1:0] f_bitrev(input logic [ADDR_W-1:0] v);
        logic [ADDR_W-1:0] r;
        for (int i = 0; i < ADDR_W; i++) begin
            r[i] = v[ADDR_W-1-i];
        end
        return r;
    endfunction

    // Divide by 2^16 and round to nearest, ties away from zero.
    function automatic logic signed [DATA_W-1:0] f_rnd16(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] s;
        s = v + $signed({{(ACC_W-16){1'b0}}, 16'h8000})
              - $signed({{(ACC_W-1){1'b0}}, v[ACC_W-1]});
        return DATA_W'(s >>> 16);
    endfunction

endpackage

// ----- rtl/core/stft_sqrt.sv -----
// ============================================================================
// STFT magnitude square root
// Bit-pair iterative integer square root with round to nearest and
// saturation to the magnitude width.
// ============================================================================
module stft_sqrt import stft_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MUL_W-1:0] i_radicand,
    output logic             o_done,
    output logic [MAG_W-1:0] o_root
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]       r_state;
    logic [MUL_W-1:0] r_v;
    logic [MUL_W-1:0] r_res;
    logic [MUL_W-1:0] r_bit;
    logic             r_done;
    logic [MAG_W-1:0] r_root;
    logic [MUL_W-1:0] trial;
    logic [MUL_W-1:0] rounded;

    assign trial   = r_res + r_bit;
    assign rounded = r_res + MUL_W'(r_v > r_res);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_v     <= i_radicand;
                        r_res   <= '0;
                        r_bit   <= MUL_W'(1) << (MUL_W - 2);
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (r_v >= trial) begin
                        r_v   <= r_v - trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_root  <= (rounded > MUL_W'(MAG_MAX)) ? MAG_MAX : rounded[MAG_W-1:0];
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ----- rtl/core/stft_fft.sv -----
// ============================================================================
// STFT frame engine
// Sample store, windowed load, in-place radix-2 FFT on one shared multiplier,
// and magnitude readout two bins per word.
// ============================================================================
module stft_fft import stft_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_smp_wr    i_smp_wr,
    input  logic       i_launch,
    input  t_frame_cmd i_cmd,
    output logic       o_busy,
    output logic       o_valid,
    output t_out_word  o_word
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_LD_RD   = 5'd1;
    localparam logic [4:0] S_LD_MUL  = 5'd2;
    localparam logic [4:0] S_LD_WR   = 5'd3;
    localparam logic [4:0] S_BF_RD   = 5'd4;
    localparam logic [4:0] S_BF_M0   = 5'd5;
    localparam logic [4:0] S_BF_M1   = 5'd6;
    localparam logic [4:0] S_BF_M2   = 5'd7;
    localparam logic [4:0] S_BF_M3   = 5'd8;
    localparam logic [4:0] S_BF_M4   = 5'd9;
    localparam logic [4:0] S_BF_M5   = 5'd10;
    localparam logic [4:0] S_BF_WA   = 5'd11;
    localparam logic [4:0] S_BF_WB   = 5'd12;
    localparam logic [4:0] S_MG_RD   = 5'd13;
    localparam logic [4:0] S_MG_SQR  = 5'd14;
    localparam logic [4:0] S_MG_SQI  = 5'd15;
    localparam logic [4:0] S_MG_SUM  = 5'd16;
    localparam logic [4:0] S_MG_ROOT = 5'd17;
    localparam logic [4:0] S_MG_WAIT = 5'd18;

    logic [4:0]               r_state;
    logic [ADDR_W-1:0]        r_off;
    logic [FRAME_W-1:0]       r_frame;
    logic [ADDR_W-1:0]        r_cnt;
    logic [STG_W-1:0]         r_stage;
    logic                     r_odd;
    logic [MAG_W-1:0]         r_mag_even;
    logic                     r_valid;
    t_out_word                r_word;

    logic signed [SMP_W-1:0]  r_smp_mem [FFT_SIZE];
    logic signed [SMP_W-1:0]  r_smp;
    logic [MUL_W-1:0]         r_tf_mem [FFT_SIZE];
    logic [MUL_W-1:0]         r_rd_a;
    logic [MUL_W-1:0]         r_rd_b;

    logic signed [MUL_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [DATA_W-1:0] r_tr;
    logic signed [DATA_W-1:0] r_ti;

    logic [ADDR_W-1:0]        mask;
    logic [ADDR_W-1:0]        bf_m;
    logic [ADDR_W-1:0]        ia;
    logic [ADDR_W-1:0]        ib;
    logic [STG_W:0]           stage_p1;
    logic [STG_W-1:0]         tw_sh;
    logic [ADDR_W-2:0]        tw_idx;
    logic signed [TW_W-1:0]   cw;
    logic signed [TW_W-1:0]   sw;
    logic signed [DATA_W-1:0] a_re;
    logic signed [DATA_W-1:0] a_im;
    logic signed [DATA_W-1:0] b_re;
    logic signed [DATA_W-1:0] b_im;
    logic signed [DATA_W-1:0] mul_a;
    logic signed [DATA_W-1:0] mul_b;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr_a;
    logic                     tf_we;
    logic [ADDR_W-1:0]        tf_waddr;
    logic [MUL_W-1:0]         tf_wdata;
    logic                     sq_start;
    logic                     sq_done;
    logic [MAG_W-1:0]         sq_root;

    // Butterfly addressing: the butterfly count with a zero inserted at the
    // stage bit gives the upper leg; the twiddle index scales the offset.
    assign mask     = (ADDR_W'(1) << r_stage) - ADDR_W'(1);
    assign bf_m     = r_cnt & mask;
    assign stage_p1 = {1'b0, r_stage} + (STG_W+1)'(1);
    assign ia       = ((r_cnt >> r_stage) << stage_p1) | bf_m;
    assign ib       = ia | (ADDR_W'(1) << r_stage);
    assign tw_sh    = STG_W'(LOG2_N - 1) - r_stage;
    assign tw_idx   = (ADDR_W-1)'(bf_m << tw_sh);
    assign cw       = COS_TAB[tw_idx];
    assign sw       = SIN_TAB[tw_idx];

    assign a_re = r_rd_a[MUL_W-1:DATA_W];
    assign a_im = r_rd_a[DATA_W-1:0];
    assign b_re = r_rd_b[MUL_W-1:DATA_W];
    assign b_im = r_rd_b[DATA_W-1:0];

    assign rd_en     = (r_state == S_BF_RD) || (r_state == S_MG_RD);
    assign rd_addr_a = (r_state == S_MG_RD) ? r_cnt : ia;
    assign sq_start  = (r_state == S_MG_ROOT);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_LD_MUL: begin
                mul_a = DATA_W'(r_smp);
                mul_b = $signed(DATA_W'(HANN_TAB[r_cnt]));
            end
            S_BF_M0: begin mul_a = DATA_W'(cw); mul_b = b_re; end
            S_BF_M1: begin mul_a = DATA_W'(sw); mul_b = b_im; end
            S_BF_M2: begin mul_a = DATA_W'(cw); mul_b = b_im; end
            S_BF_M3: begin mul_a = DATA_W'(sw); mul_b = b_re; end
            S_MG_SQR: begin mul_a = a_re; mul_b = a_re; end
            S_MG_SQI: begin mul_a = a_im; mul_b = a_im; end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        tf_we    = 1'b0;
        tf_waddr = ia;
        tf_wdata = '0;
        unique case (r_state)
            S_LD_WR: begin
                tf_we    = 1'b1;
                tf_waddr = f_bitrev(r_cnt);
                tf_wdata = {f_rnd16(ACC_W'(r_prod)), {DATA_W{1'b0}}};
            end
            S_BF_WA: begin
                tf_we    = 1'b1;
                tf_waddr = ia;
                tf_wdata = {DATA_W'(a_re + r_tr), DATA_W'(a_im + r_ti)};
            end
            S_BF_WB: begin
                tf_we    = 1'b1;
                tf_waddr = ib;
                tf_wdata = {DATA_W'(a_re - r_tr), DATA_W'(a_im - r_ti)};
            end
            default: begin
                tf_we    = 1'b0;
                tf_waddr = ia;
                tf_wdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_smp_wr.en) begin
            r_smp_mem[i_smp_wr.addr] <= i_smp_wr.data;
        end
        r_smp <= r_smp_mem[r_off + r_cnt];
    end

    always_ff @(posedge i_clk) begin
        if (tf_we) begin
            r_tf_mem[tf_waddr] <= tf_wdata;
        end
        if (rd_en) begin
            r_rd_a <= r_tf_mem[rd_addr_a];
            r_rd_b <= r_tf_mem[ib];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            S_BF_M1:  r_acc <= ACC_W'(r_prod);
            S_BF_M2:  r_acc <= r_acc + ACC_W'(r_prod);
            S_BF_M3: begin
                r_tr  <= f_rnd16(r_acc);
                r_acc <= ACC_W'(r_prod);
            end
            S_BF_M4:  r_acc <= r_acc - ACC_W'(r_prod);
            S_BF_M5:  r_ti  <= f_rnd16(r_acc);
            S_MG_SQI: r_acc <= ACC_W'(r_prod);
            S_MG_SUM: r_acc <= r_acc + ACC_W'(r_prod);
            default:  r_acc <= r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_stage <= '0;
            r_odd   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_launch) begin
                        r_off   <= i_cmd.offset;
                        r_frame <= i_cmd.frame;
                        r_cnt   <= '0;
                        r_state <= S_LD_RD;
                    end
                end
                S_LD_RD:  r_state <= S_LD_MUL;
                S_LD_MUL: r_state <= S_LD_WR;
                S_LD_WR: begin
                    r_cnt <= r_cnt + ADDR_W'(1);
                    if (&r_cnt) begin
                        r_stage <= '0;
                        r_state <= S_BF_RD;
                    end else begin
                        r_state <= S_LD_RD;
                    end
                end
                S_BF_RD: r_state <= S_BF_M0;
                S_BF_M0: r_state <= S_BF_M1;
                S_BF_M1: r_state <= S_BF_M2;
                S_BF_M2: r_state <= S_BF_M3;
                S_BF_M3: r_state <= S_BF_M4;
                S_BF_M4: r_state <= S_BF_M5;
                S_BF_M5: r_state <= S_BF_WA;
                S_BF_WA: r_state <= S_BF_WB;
                S_BF_WB: begin
                    if (r_cnt == ADDR_W'(HALF_N - 1)) begin
                        r_cnt <= '0;
                        if (r_stage == STG_W'(LOG2_N - 1)) begin
                            r_odd   <= 1'b0;
                            r_state <= S_MG_RD;
                        end else begin
                            r_stage <= r_stage + STG_W'(1);
                            r_state <= S_BF_RD;
                        end
                    end else begin
                        r_cnt   <= r_cnt + ADDR_W'(1);
                        r_state <= S_BF_RD;
                    end
                end
                S_MG_RD:   r_state <= S_MG_SQR;
                S_MG_SQR:  r_state <= S_MG_SQI;
                S_MG_SQI:  r_state <= S_MG_SUM;
                S_MG_SUM:  r_state <= S_MG_ROOT;
                S_MG_ROOT: r_state <= S_MG_WAIT;
                S_MG_WAIT: begin
                    if (sq_done) begin
                        r_cnt <= r_cnt + ADDR_W'(1);
                        if (!r_odd) begin
                            r_mag_even <= sq_root;
                            r_odd      <= 1'b1;
                            r_state    <= S_MG_RD;
                        end else begin
                            r_odd                <= 1'b0;
                            r_valid              <= 1'b1;
                            r_word.pair_index     <= PAIR_W'(r_cnt >> 1);
                            r_word.magnitude_even <= r_mag_even;
                            r_word.magnitude_odd  <= sq_root;
                            r_word.frame_number   <= r_frame;
                            r_word.last           <= (r_cnt == ADDR_W'(HALF_N - 1));
                            if (r_cnt == ADDR_W'(HALF_N - 1)) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_state <= S_MG_RD;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    stft_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (r_acc[MUL_W-1:0]),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ----- rtl/core/stft_magnitude_spectrogram.sv -----
// ============================================================================
// STFT magnitude spectrogram
// Frames incoming audio samples, applies a Hann window and a 256-point
// radix-2 FFT, and streams the magnitudes of the lower half of the bins.
// ============================================================================
//
//  channel   ports                                   handshake
//  -------   -------------------------------------   ------------------------
//  input     i_start, i_word, o_busy                 i_start & !o_busy
//  output    o_valid, o_word                         o_valid, one cycle
//  config    i_cfg_we, i_cfg_index, i_cfg_data       i_cfg_we
//
// A sample that completes no frame is taken without raising o_busy. A sample
// that completes a frame keeps o_busy high while the engine loads the
// windowed points, runs the butterflies on the shared multiplier, and then
// makes the magnitude pass, one square root per bin. Reset is synchronous
// and active low. Result words cannot be stalled; each is shown for exactly
// one cycle.
module stft_magnitude_spectrogram import stft_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_in_word         i_word,
    output logic             o_busy,
    output logic             o_valid,
    output t_out_word        o_word,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic [HOP_W-1:0]   r_hop_len;
    logic [FRAME_W-1:0] r_fps;
    logic [ADDR_W-1:0]  r_wr_pos;
    logic [FILL_W-1:0]  r_fill;
    logic [HOP_W-1:0]   r_hop;
    logic [FRAME_W-1:0] r_done;

    logic               accept;
    logic               active;
    logic               ready;
    logic [FILL_W-1:0]  fill_c;
    logic [HOP_W-1:0]   hop_c;
    logic [FRAME_W-1:0] done_c;
    logic [FILL_W-1:0]  n_fill;
    logic [HOP_W-1:0]   n_hop;
    logic [HOP_W-1:0]   hop_inc;
    logic               launch;
    t_smp_wr            smp_wr;
    t_frame_cmd         cmd;

    assign accept = i_start && !o_busy;
    assign fill_c = i_word.first ? '0 : r_fill;
    assign hop_c  = i_word.first ? '0 : r_hop;
    assign done_c = i_word.first ? '0 : r_done;
    assign active = (done_c < r_fps);
    assign hop_inc = hop_c + HOP_W'(1);

    // Until the store is full, a frame comes at the point it fills; after
    // that, one comes every hop_length samples.
    always_comb begin
        if (fill_c < FILL_W'(FFT_SIZE)) begin
            n_fill = fill_c + FILL_W'(1);
            ready  = (n_fill == FILL_W'(FFT_SIZE));
            n_hop  = ready ? '0 : hop_c;
        end else begin
            n_fill = fill_c;
            ready  = (hop_inc >= r_hop_len);
            n_hop  = ready ? '0 : hop_inc;
        end
    end

    assign launch      = accept && active && ready;
    assign smp_wr.en   = accept && active;
    assign smp_wr.addr = r_wr_pos;
    assign smp_wr.data = i_word.sample;
    assign cmd.offset  = r_wr_pos + ADDR_W'(1);
    assign cmd.frame   = done_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hop_len <= HOP_W'(128);
            r_fps     <= FRAME_W'(124);
            r_wr_pos  <= '0;
            r_fill    <= '0;
            r_hop     <= '0;
            r_done    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_HOP_LENGTH:        r_hop_len <= i_cfg_data[HOP_W-1:0];
                    CFG_FRAMES_PER_SIGNAL: r_fps     <= i_cfg_data[FRAME_W-1:0];
                    default: r_fps <= r_fps;
                endcase
            end
            if (accept) begin
                if (active) begin
                    r_wr_pos <= r_wr_pos + ADDR_W'(1);
                    r_fill   <= n_fill;
                    r_hop    <= n_hop;
                    r_done   <= ready ? done_c + FRAME_W'(1) : done_c;
                end else begin
                    r_fill <= fill_c;
                    r_hop  <= hop_c;
                    r_done <= done_c;
                end
            end
        end
    end

    stft_fft u_fft (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_smp_wr (smp_wr),
        .i_launch (launch),
        .i_cmd    (cmd),
        .o_busy   (o_busy),
        .o_valid  (o_valid),
        .o_word   (o_word)
    );

`ifndef NO_ASSERTIONS
    // Result words of one frame are spread out by the magnitude pass.
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back-to-back result words");

    // An idle engine has no word pending.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> !o_valid)
        else $error("result word after an idle accept");

    // Only the final word of a frame may coincide with the engine going idle.
    a_busy_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_word.last) |-> o_busy)
        else $error("engine idle in the middle of a frame");
`endif

endmodule
